// ===== rtl/pim_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pim_pkg
// Shared types and constants for the inverse perspective coordinate mapper.
// ----------------------------------------------------------------------------
package pim_pkg;

    // coefficient format: signed Q15.32
    localparam int COEF_W   = 48;
    localparam int NUM_COEF = 8;
    localparam int IDX_W    = $clog2(NUM_COEF);
    localparam int FIELD_W  = 12;
    localparam int OUT_W    = 32;
    // the quotient is formed as Q.16
    localparam int FRAC_SH  = 16;
    // quotient bits kept by the divider; anything wider saturates
    localparam int QBITS    = 33;
    localparam int ONE_POS  = 32;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_M00 = 3'd0;
    localparam logic [IDX_W-1:0] CFG_M01 = 3'd1;
    localparam logic [IDX_W-1:0] CFG_M02 = 3'd2;
    localparam logic [IDX_W-1:0] CFG_M10 = 3'd3;
    localparam logic [IDX_W-1:0] CFG_M11 = 3'd4;
    localparam logic [IDX_W-1:0] CFG_M12 = 3'd5;
    localparam logic [IDX_W-1:0] CFG_M20 = 3'd6;
    localparam logic [IDX_W-1:0] CFG_M21 = 3'd7;

    localparam logic [COEF_W-1:0] COEF_ONE = 48'h0001_0000_0000;

    localparam logic [OUT_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef logic [NUM_COEF-1:0][COEF_W-1:0] t_coef_set;

    // identity matrix, highest index first: m21 m20 m12 m11 m10 m02 m01 m00
    localparam t_coef_set COEF_RESET = {48'h0, 48'h0, 48'h0, COEF_ONE,
                                        48'h0, 48'h0, 48'h0, COEF_ONE};

    typedef struct packed {
        logic [FIELD_W-1:0] dest_x;
        logic [FIELD_W-1:0] dest_y;
    } t_in_word;

    typedef struct packed {
        logic signed [OUT_W-1:0] source_x;
        logic signed [OUT_W-1:0] source_y;
        logic                    invalid;
    } t_out_word;

    // classification made by the front end for each word
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic zero_x;
        logic zero_y;
        logic den_zero;
    } t_flags;

endpackage

// ===== rtl/perspective_inverse_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_inverse_map
// Maps a destination pixel to its source coordinate through an inverse
// homography with the last entry fixed at one.
// ----------------------------------------------------------------------------
// A new coordinate may be started every clock cycle; busy never rises since
// the back end drains the queue every cycle. Each result appears on o_result
// with o_strobe high for one cycle, in start order; the receiver must take it
// then. The path is 39 register stages, the first loaded at the accepting
// edge: three front stages (products, sums, magnitudes), one queue entry, 34
// stages of the two bit-per-stage dividers and one saturation stage.
// The user must write coefficients through i_cfg_* only while no coordinate
// is in flight; the block itself does not enforce it.
module perspective_inverse_map #(
    parameter int COORD_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  pim_pkg::t_in_word             i_cmd,
    output logic                          o_strobe,
    output pim_pkg::t_out_word            o_result,
    input  logic                          i_cfg_we,
    input  logic [pim_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [pim_pkg::COEF_W-1:0]    i_cfg_data
);

    localparam int CW = (COORD_BITS < pim_pkg::FIELD_W) ? COORD_BITS : pim_pkg::FIELD_W;
    localparam int SW = pim_pkg::COEF_W + CW + 3;
    localparam int QW = 3 * SW + $bits(pim_pkg::t_flags);

    pim_pkg::t_coef_set r_coef;
    logic               accept;
    logic               f_valid;
    logic [SW-1:0]      f_mx, f_my, f_md;
    pim_pkg::t_flags    f_fl, q_fl;
    logic               q_valid, q_full;
    logic [QW-1:0]      q_data;
    logic [SW-1:0]      q_mx, q_my, q_md;

    assign accept = start & ~busy;
    assign busy   = q_full;

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= pim_pkg::COEF_RESET;
        end else if (i_cfg_we) begin
            r_coef[i_cfg_idx] <= i_cfg_data;
        end
    end

    pim_front #(.CW(CW), .SW(SW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_x     (i_cmd.dest_x[CW-1:0]),
        .i_y     (i_cmd.dest_y[CW-1:0]),
        .i_coef  (r_coef),
        .o_valid (f_valid),
        .o_mag_x (f_mx),
        .o_mag_y (f_my),
        .o_mag_d (f_md),
        .o_flags (f_fl)
    );

    pim_queue #(.W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_mx, f_my, f_md, f_fl}),
        .i_pop   (q_valid),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_data)
    );

    assign {q_mx, q_my, q_md, q_fl} = q_data;

    pim_back #(.MW(SW)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_mag_x (q_mx),
        .i_mag_y (q_my),
        .i_mag_d (q_md),
        .i_flags (q_fl),
        .o_valid (o_strobe),
        .o_word  (o_result)
    );

endmodule

// ===== rtl/pim_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pim_front
// Multiplies, sums and classifies each coordinate; three register stages.
// ----------------------------------------------------------------------------
module pim_front #(
    parameter int CW = 12,
    parameter int SW = 63
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [CW-1:0]                i_x,
    input  logic [CW-1:0]                i_y,
    input  pim_pkg::t_coef_set           i_coef,
    output logic                         o_valid,
    output logic [SW-1:0]                o_mag_x,
    output logic [SW-1:0]                o_mag_y,
    output logic [SW-1:0]                o_mag_d,
    output pim_pkg::t_flags              o_flags
);

    localparam int PW = pim_pkg::COEF_W + CW + 1;

    logic signed [CW:0]               xs, ys;
    logic signed [PW-1:0]             r_p [6];
    logic signed [SW-1:0]             r_sx, r_sy, r_sd;
    logic                             r_v1, r_v2, r_v3;
    logic [SW-1:0]                    r_mx, r_my, r_md;
    pim_pkg::t_flags                  r_fl;
    logic signed [SW-1:0]             off_x, off_y, one_d;
    pim_pkg::t_flags                  n_fl;

    assign xs = $signed({1'b0, i_x});
    assign ys = $signed({1'b0, i_y});

    // constant terms at sum width
    assign off_x = SW'($signed(i_coef[pim_pkg::CFG_M02]));
    assign off_y = SW'($signed(i_coef[pim_pkg::CFG_M12]));
    assign one_d = SW'(1) <<< pim_pkg::ONE_POS;

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage 1: six products
    always_ff @(posedge i_clk) begin
        r_p[0] <= $signed(i_coef[pim_pkg::CFG_M00]) * xs;
        r_p[1] <= $signed(i_coef[pim_pkg::CFG_M01]) * ys;
        r_p[2] <= $signed(i_coef[pim_pkg::CFG_M10]) * xs;
        r_p[3] <= $signed(i_coef[pim_pkg::CFG_M11]) * ys;
        r_p[4] <= $signed(i_coef[pim_pkg::CFG_M20]) * xs;
        r_p[5] <= $signed(i_coef[pim_pkg::CFG_M21]) * ys;
    end

    // stage 2: numerators and denominator
    always_ff @(posedge i_clk) begin
        r_sx <= SW'(r_p[0]) + SW'(r_p[1]) + off_x;
        r_sy <= SW'(r_p[2]) + SW'(r_p[3]) + off_y;
        r_sd <= SW'(r_p[4]) + SW'(r_p[5]) + one_d;
    end

    // signs and zero tests
    always_comb begin
        n_fl.zero_x   = (r_sx == '0);
        n_fl.zero_y   = (r_sy == '0);
        n_fl.den_zero = (r_sd == '0);
        n_fl.neg_x    = (r_sx[SW-1] ^ r_sd[SW-1]) & ~n_fl.zero_x;
        n_fl.neg_y    = (r_sy[SW-1] ^ r_sd[SW-1]) & ~n_fl.zero_y;
    end

    // stage 3: magnitudes
    always_ff @(posedge i_clk) begin
        r_mx <= r_sx[SW-1] ? SW'(-r_sx) : SW'(r_sx);
        r_my <= r_sy[SW-1] ? SW'(-r_sy) : SW'(r_sy);
        r_md <= r_sd[SW-1] ? SW'(-r_sd) : SW'(r_sd);
        r_fl <= n_fl;
    end

    assign o_valid = r_v3;
    assign o_mag_x = r_mx;
    assign o_mag_y = r_my;
    assign o_mag_d = r_md;
    assign o_flags = r_fl;

endmodule

// ===== rtl/pim_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pim_queue
// Two-entry word queue between the front end and the divider back end.
// ----------------------------------------------------------------------------
module pim_queue #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_valid,
    output logic         o_full,
    output logic [W-1:0] o_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [PTR_W:0]   r_cnt;
    logic             do_pop;

    assign do_pop  = i_pop & o_valid;
    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (PTR_W + 1)'(DEPTH));
    assign o_data  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PTR_W + 1)'(i_push) - (PTR_W + 1)'(do_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

`ifndef ASSERT_OFF
    // the back end drains every cycle, so the queue holds at most one word
    a_shallow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PTR_W + 1)'(1))
        else $error("queue holds more than one word");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
`endif

endmodule

// ===== rtl/pim_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pim_div
// Pipelined restoring divider: (num << 16) / den, one quotient bit a stage.
// ----------------------------------------------------------------------------
module pim_div #(
    parameter int MW = 63
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [MW-1:0]               i_num,
    input  logic [MW-1:0]               i_den,
    output logic                        o_valid,
    output logic [pim_pkg::QBITS-1:0]   o_quo,
    output logic                        o_ovf
);

    localparam int Q  = pim_pkg::QBITS;
    localparam int NW = MW + pim_pkg::FRAC_SH;
    localparam int HW = NW - Q;

    logic [NW-1:0] dividend;
    logic [HW-1:0] hi;

    logic          r_vld [Q+1];
    logic [MW-1:0] r_rem [Q+1];
    logic [MW-1:0] r_d   [Q+1];
    logic [Q-1:0]  r_nlo [Q+1];
    logic [Q-1:0]  r_q   [Q+1];
    logic          r_ovf [Q+1];

    assign dividend = {i_num, {pim_pkg::FRAC_SH{1'b0}}};
    assign hi       = dividend[NW-1:Q];

    // stage 0: overflow check and initial partial remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld[0] <= 1'b0;
        else          r_vld[0] <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= MW'(hi);
        r_d[0]   <= i_den;
        r_nlo[0] <= dividend[Q-1:0];
        r_q[0]   <= '0;
        r_ovf[0] <= ({{(MW-HW){1'b0}}, hi} >= i_den);
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= Q; k++) begin : g_stage
        logic [MW:0] shifted;
        logic [MW:0] diff;
        logic        take;

        assign shifted = {r_rem[k-1], r_nlo[k-1][Q-1]};
        assign diff    = shifted - {1'b0, r_d[k-1]};
        assign take    = (shifted >= {1'b0, r_d[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld[k] <= 1'b0;
            else          r_vld[k] <= r_vld[k-1];
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= take ? diff[MW-1:0] : shifted[MW-1:0];
            r_d[k]   <= r_d[k-1];
            r_nlo[k] <= {r_nlo[k-1][Q-2:0], 1'b0};
            r_q[k]   <= {r_q[k-1][Q-2:0], take};
            r_ovf[k] <= r_ovf[k-1];
        end
    end

    assign o_valid = r_vld[Q];
    assign o_quo   = r_q[Q];
    assign o_ovf   = r_ovf[Q];

`ifndef ASSERT_OFF
    // without overflow the remainder stays below the divisor to the end
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[Q] && !r_ovf[Q]) |-> (r_rem[Q] < r_d[Q]))
        else $error("divider remainder not reduced");
`endif

endmodule

// ===== rtl/pim_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pim_back
// Divides both numerators by the denominator and saturates the results.
// ----------------------------------------------------------------------------
module pim_back #(
    parameter int MW = 63
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [MW-1:0]        i_mag_x,
    input  logic [MW-1:0]        i_mag_y,
    input  logic [MW-1:0]        i_mag_d,
    input  pim_pkg::t_flags      i_flags,
    output logic                 o_valid,
    output pim_pkg::t_out_word   o_word
);

    localparam int Q = pim_pkg::QBITS;

    logic                     vx, vy, ovx, ovy;
    logic [Q-1:0]             qx, qy;
    pim_pkg::t_flags          r_fl [Q+1];
    pim_pkg::t_flags          fl;
    logic                     r_valid;
    pim_pkg::t_out_word       r_word;
    logic [pim_pkg::OUT_W-1:0] n_sx, n_sy;
    logic                     satx, saty;

    pim_div #(.MW(MW)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_num   (i_mag_x),
        .i_den   (i_mag_d),
        .o_valid (vx),
        .o_quo   (qx),
        .o_ovf   (ovx)
    );

    pim_div #(.MW(MW)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_num   (i_mag_y),
        .i_den   (i_mag_d),
        .o_valid (vy),
        .o_quo   (qy),
        .o_ovf   (ovy)
    );

    // flags travel alongside the divider stages
    always_ff @(posedge i_clk) begin
        r_fl[0] <= i_flags;
        for (int k = 1; k <= Q; k++) r_fl[k] <= r_fl[k-1];
    end

    assign fl = r_fl[Q];

    // saturation and sign
    function automatic logic [pim_pkg::OUT_W-1:0] f_final(
        input logic [Q-1:0] q, input logic ovf, input logic neg,
        input logic zero, input logic dz, output logic sat);
        logic [Q-1:0] limit;
        logic [pim_pkg::OUT_W-1:0] res;
        limit = neg ? Q'(pim_pkg::SAT_MIN) : Q'(pim_pkg::SAT_MAX);
        sat   = 1'b0;
        if (dz) begin
            sat = 1'b1;
            res = zero ? '0 : (neg ? pim_pkg::SAT_MIN : pim_pkg::SAT_MAX);
        end else if (ovf || q > limit) begin
            sat = 1'b1;
            res = neg ? pim_pkg::SAT_MIN : pim_pkg::SAT_MAX;
        end else begin
            res = neg ? (~q[pim_pkg::OUT_W-1:0] + 1'b1) : q[pim_pkg::OUT_W-1:0];
        end
        return res;
    endfunction

    always_comb begin
        n_sx = f_final(qx, ovx, fl.neg_x, fl.zero_x, fl.den_zero, satx);
        n_sy = f_final(qy, ovy, fl.neg_y, fl.zero_y, fl.den_zero, saty);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= vx & vy;
    end

    always_ff @(posedge i_clk) begin
        r_word.source_x <= $signed(n_sx);
        r_word.source_y <= $signed(n_sy);
        r_word.invalid  <= satx | saty;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for perspective_inverse_map. Coefficient sets are
// loaded while the mapper is idle, coordinate words are started with random
// gaps in all random phases but the last, and every result word is compared
// to an in-bench fixed-point model of the homography divide with saturation.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 60;
    localparam int RAND_PHASES  = 18;
    localparam int WORDS_PER_PH = 100;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    pim_pkg::t_in_word             i_cmd;
    logic                          o_strobe;
    pim_pkg::t_out_word            o_result;
    logic                          i_cfg_we;
    logic [pim_pkg::IDX_W-1:0]     i_cfg_idx;
    logic [pim_pkg::COEF_W-1:0]    i_cfg_data;

    // bench copy of the coefficient registers
    logic [pim_pkg::COEF_W-1:0]    coef_reg [pim_pkg::NUM_COEF];
    pim_pkg::t_out_word            coord_fifo [$];
    int                            err_cnt;
    int                            word_cnt;
    int                            result_cnt;
    int                            invalid_cnt;
    int                            cycle_cnt;
    bit                            gaps_on;

    // directed table: coefficient writes and coordinate words
    typedef struct {
        bit                         is_cfg;
        logic [pim_pkg::IDX_W-1:0]  idx;
        logic [pim_pkg::COEF_W-1:0] data;
        logic [11:0]                x;
        logic [11:0]                y;
        bit                         has_exp;
        pim_pkg::t_out_word         exp;
    } t_row;

    t_row                          rows [$];

    perspective_inverse_map uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // quotient of signed Q.32 values as signed Q15.16, truncated toward zero and saturated
    function automatic logic [pim_pkg::OUT_W-1:0] q_div(
        input logic signed [127:0] num,
        input logic signed [127:0] den,
        output bit sat);
        logic [127:0] n_mag;
        logic [127:0] d_mag;
        logic [127:0] quo;
        logic [127:0] lim;
        bit           neg;
        sat = 1'b0;
        if (den == 0) begin
            sat = 1'b1;
            if (num == 0) return '0;
            return (num < 0) ? pim_pkg::SAT_MIN : pim_pkg::SAT_MAX;
        end
        n_mag = (num < 0) ? -num : num;
        d_mag = (den < 0) ? -den : den;
        neg   = ((num < 0) != (den < 0)) && (num != 0);
        quo   = (n_mag << pim_pkg::FRAC_SH) / d_mag;
        lim   = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (quo > lim) begin
            quo = lim;
            sat = 1'b1;
        end
        if (neg) quo = -quo;
        return quo[pim_pkg::OUT_W-1:0];
    endfunction

    function automatic logic signed [127:0] coef_term(
        input logic [pim_pkg::COEF_W-1:0] c,
        input logic [11:0] v);
        logic signed [127:0] cs;
        logic signed [127:0] vs;
        cs = {{(128-pim_pkg::COEF_W){c[pim_pkg::COEF_W-1]}}, c};
        vs = {116'b0, v};
        return cs * vs;
    endfunction

    // expected source coordinate for one destination word
    function automatic pim_pkg::t_out_word map_coord(input pim_pkg::t_in_word w);
        logic signed [127:0] nx;
        logic signed [127:0] ny;
        logic signed [127:0] dn;
        bit                  sx;
        bit                  sy;
        pim_pkg::t_out_word  r;
        nx = coef_term(coef_reg[pim_pkg::CFG_M00], w.dest_x)
             + coef_term(coef_reg[pim_pkg::CFG_M01], w.dest_y)
             + coef_term(coef_reg[pim_pkg::CFG_M02], 12'd1);
        ny = coef_term(coef_reg[pim_pkg::CFG_M10], w.dest_x)
             + coef_term(coef_reg[pim_pkg::CFG_M11], w.dest_y)
             + coef_term(coef_reg[pim_pkg::CFG_M12], 12'd1);
        dn = coef_term(coef_reg[pim_pkg::CFG_M20], w.dest_x)
             + coef_term(coef_reg[pim_pkg::CFG_M21], w.dest_y)
             + (128'sd1 <<< 32);
        r.source_x = q_div(nx, dn, sx);
        r.source_y = q_div(ny, dn, sy);
        r.invalid  = sx | sy | (dn == 0);
        return r;
    endfunction

    // random coefficient: extremes, zero, or a random magnitude
    function automatic logic [pim_pkg::COEF_W-1:0] rand_coef(input int min_sh);
        logic [63:0] mag;
        int          k;
        k = $urandom_range(0, 9);
        case (k)
            0: return 48'h7FFF_FFFF_FFFF;
            1: return 48'h8000_0000_0000;
            2: return '0;
            default: begin
                mag = {$urandom, $urandom} >> $urandom_range(min_sh, 63);
                if ($urandom_range(0, 1)) mag = -mag;
                return mag[pim_pkg::COEF_W-1:0];
            end
        endcase
    endfunction

    // append one row to the directed table
    task automatic add_row(input t_row rr);
        rows.insert(rows.size(), rr);
    endtask

    // wait for all results before touching the coefficients
    task automatic wait_drained();
        while (coord_fifo.size() != 0) @(posedge i_clk);
    endtask

    // write enable stays high until the next word is started
    task automatic write_coef(input logic [pim_pkg::IDX_W-1:0] idx,
                              input logic [pim_pkg::COEF_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        coef_reg[idx] = val;
    endtask

    // start one word, holding start until it is taken
    task automatic send_word(input pim_pkg::t_in_word w, output pim_pkg::t_out_word exp);
        int gap;
        i_cfg_we <= 1'b0;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            gap = $urandom_range(1, 14);
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= w;
        do @(posedge i_clk); while (busy);
        exp = map_coord(w);
        coord_fifo.insert(coord_fifo.size(), exp);
        word_cnt++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        pim_pkg::t_out_word exp;
        if (i_rst_n && o_strobe) begin
            result_cnt++;
            if (o_result.invalid) invalid_cnt++;
            if (coord_fifo.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result word x=%h y=%h inv=%b",
                             o_result.source_x, o_result.source_y, o_result.invalid);
            end else begin
                exp = coord_fifo.pop_front();
                if (o_result !== exp) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: exp x=%h y=%h inv=%b got x=%h y=%h inv=%b",
                                 exp.source_x, exp.source_y, exp.invalid,
                                 o_result.source_x, o_result.source_y, o_result.invalid);
                end
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_row               r;
        pim_pkg::t_in_word  w;
        pim_pkg::t_out_word got_exp;

        err_cnt     = 0;
        word_cnt    = 0;
        result_cnt  = 0;
        invalid_cnt = 0;
        cycle_cnt   = 0;
        gaps_on     = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        coef_reg[pim_pkg::CFG_M00] = pim_pkg::COEF_ONE;
        coef_reg[pim_pkg::CFG_M01] = '0;
        coef_reg[pim_pkg::CFG_M02] = '0;
        coef_reg[pim_pkg::CFG_M10] = '0;
        coef_reg[pim_pkg::CFG_M11] = pim_pkg::COEF_ONE;
        coef_reg[pim_pkg::CFG_M12] = '0;
        coef_reg[pim_pkg::CFG_M20] = '0;
        coef_reg[pim_pkg::CFG_M21] = '0;

        // identity after reset
        add_row('{0, pim_pkg::CFG_M00, 0, 12'd0, 12'd0, 1, '{32'h0, 32'h0, 1'b0}});
        add_row('{0, pim_pkg::CFG_M00, 0, 12'd4095, 12'd4095, 1,
                  '{32'h0FFF_0000, 32'h0FFF_0000, 1'b0}});
        add_row('{0, pim_pkg::CFG_M00, 0, 12'd1, 12'd4095, 1,
                  '{32'h0001_0000, 32'h0FFF_0000, 1'b0}});
        add_row('{0, pim_pkg::CFG_M00, 0, 12'hAAA, 12'h555, 1,
                  '{32'h0AAA_0000, 32'h0555_0000, 1'b0}});
        // denominator 1 - x: zero at x = 1, negative beyond
        add_row('{1, pim_pkg::CFG_M10, -pim_pkg::COEF_ONE, 0, 0, 0, '{0, 0, 0}});
        add_row('{1, pim_pkg::CFG_M11, 48'h0, 0, 0, 0, '{0, 0, 0}});
        add_row('{1, pim_pkg::CFG_M20, -pim_pkg::COEF_ONE, 0, 0, 0, '{0, 0, 0}});
        add_row('{0, pim_pkg::CFG_M00, 0, 12'd1, 12'd0, 1,
                  '{pim_pkg::SAT_MAX, pim_pkg::SAT_MIN, 1'b1}});
        add_row('{0, pim_pkg::CFG_M00, 0, 12'd0, 12'd7, 1, '{32'h0, 32'h0, 1'b0}});
        add_row('{0, pim_pkg::CFG_M00, 0, 12'd2, 12'd0, 1,
                  '{32'hFFFE_0000, 32'h0002_0000, 1'b0}});
        add_row('{0, pim_pkg::CFG_M00, 0, 12'd3, 12'd9, 0, '{0, 0, 0}});
        add_row('{0, pim_pkg::CFG_M00, 0, 12'd4095, 12'd0, 0, '{0, 0, 0}});
        // zero numerator over zero denominator
        add_row('{1, pim_pkg::CFG_M00, 48'h0, 0, 0, 0, '{0, 0, 0}});
        add_row('{1, pim_pkg::CFG_M10, 48'h0, 0, 0, 0, '{0, 0, 0}});
        add_row('{0, pim_pkg::CFG_M00, 0, 12'd1, 12'd4095, 1, '{32'h0, 32'h0, 1'b1}});
        // largest coefficients: saturating both ways
        add_row('{1, pim_pkg::CFG_M00, 48'h7FFF_FFFF_FFFF, 0, 0, 0, '{0, 0, 0}});
        add_row('{1, pim_pkg::CFG_M01, 48'h8000_0000_0000, 0, 0, 0, '{0, 0, 0}});
        add_row('{1, pim_pkg::CFG_M02, 48'h7FFF_FFFF_FFFF, 0, 0, 0, '{0, 0, 0}});
        add_row('{1, pim_pkg::CFG_M12, 48'h8000_0000_0000, 0, 0, 0, '{0, 0, 0}});
        add_row('{1, pim_pkg::CFG_M20, 48'h0, 0, 0, 0, '{0, 0, 0}});
        add_row('{1, pim_pkg::CFG_M21, 48'h0000_0000_1000, 0, 0, 0, '{0, 0, 0}});
        add_row('{0, pim_pkg::CFG_M00, 0, 12'd4095, 12'd0, 0, '{0, 0, 0}});
        add_row('{0, pim_pkg::CFG_M00, 0, 12'd0, 12'd4095, 0, '{0, 0, 0}});
        add_row('{0, pim_pkg::CFG_M00, 0, 12'd0, 12'd0, 0, '{0, 0, 0}});
        add_row('{0, pim_pkg::CFG_M00, 0, 12'd4095, 12'd4095, 0, '{0, 0, 0}});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (rows[i]) begin
            r = rows[i];
            if (r.is_cfg) begin
                start <= 1'b0;
                wait_drained();
                write_coef(r.idx, r.data);
            end else begin
                w.dest_x = r.x;
                w.dest_y = r.y;
                send_word(w, got_exp);
                if (r.has_exp && got_exp !== r.exp) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("model disagrees with table row %0d", i);
                end
            end
        end

        // random part: new coefficient set per phase, last phase without gaps
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            start <= 1'b0;
            wait_drained();
            for (int k = 0; k < pim_pkg::NUM_COEF; k++) begin
                if (ph == 0)
                    write_coef(pim_pkg::IDX_W'(k), 48'h7FFF_FFFF_FFFF);
                else if (ph == 1)
                    write_coef(pim_pkg::IDX_W'(k), 48'h8000_0000_0000);
                else if (ph == 2)
                    write_coef(pim_pkg::IDX_W'(k), '0);
                else
                    write_coef(pim_pkg::IDX_W'(k),
                               rand_coef(k >= pim_pkg::CFG_M20 ? 26 : 14));
            end
            gaps_on = (ph != RAND_PHASES - 1);
            for (int n = 0; n < WORDS_PER_PH; n++) begin
                case ($urandom_range(0, 7))
                    0: w.dest_x = 12'd0;
                    1: w.dest_x = 12'd4095;
                    default: w.dest_x = 12'($urandom);
                endcase
                case ($urandom_range(0, 7))
                    0: w.dest_y = 12'd0;
                    1: w.dest_y = 12'd4095;
                    default: w.dest_y = 12'($urandom);
                endcase
                send_word(w, got_exp);
            end
        end
        start <= 1'b0;

        // drain
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("mapped %0d coordinate words, %0d results, %0d flagged invalid",
                 word_cnt, result_cnt, invalid_cnt);
        $display("coefficient sets: identity, zero and negative denominators, extremes, random");
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pim_pkg.sv
rtl/pim_front.sv
rtl/pim_queue.sv
rtl/pim_div.sv
rtl/pim_back.sv
rtl/perspective_inverse_map.sv
bench/tb_top.sv
